// ----- design/ip6val_pkg.sv -----
package ip6val_pkg;

    localparam int MAX_GROUPS     = 8;
    localparam int MAX_HEX_DIGITS = 4;

    localparam int SEG_W      = $clog2(MAX_GROUPS + 2);
    localparam int HEX_W      = $clog2(MAX_HEX_DIGITS + 2);
    localparam int DOT_W      = 3;
    localparam int DOT_LIMIT  = 4;
    localparam int DEC_W      = 9;
    localparam int DEC_PROD_W = DEC_W + 4;
    localparam int DEC_MAX    = 255;
    localparam int DEC_SAT    = 256;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_UA    = 8'h41;
    localparam logic [7:0] CHAR_UF    = 8'h46;
    localparam logic [7:0] CHAR_LA    = 8'h61;
    localparam logic [7:0] CHAR_LF    = 8'h66;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CLS_DEC,
        CLS_HEX,
        CLS_COLON,
        CLS_DOT,
        CLS_BAD
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
        logic        empty;
    } item_t;

    typedef enum logic [3:0] {
        R_OK,
        R_EMPTY,
        R_TRIPLE,
        R_DOUBLE2,
        R_DOTS,
        R_SEGS,
        R_BADCHAR,
        R_HEXLONG,
        R_DECIMAL
    } reason_t;

    typedef enum logic [1:0] {
        CERR_NONE,
        CERR_TRIPLE,
        CERR_DOUBLE
    } colon_err_t;

    typedef enum logic [1:0] {
        XERR_NONE,
        XERR_BAD,
        XERR_HEXLONG,
        XERR_DECIMAL
    } char_err_t;

endpackage

// ----- design/ip6val_front.sv -----
module ip6val_front (
    input  logic [7:0]         char_code,
    input  logic               last_char,
    input  logic               empty_text,
    output ip6val_pkg::item_t  item
);

    always_comb
    begin
        item.last  = last_char;
        item.empty = empty_text;
        item.digit = char_code[3:0];
        if (char_code >= ip6val_pkg::CHAR_ZERO && char_code <= ip6val_pkg::CHAR_NINE)
        begin
            item.cls = ip6val_pkg::CLS_DEC;
        end
        else if ((char_code >= ip6val_pkg::CHAR_UA && char_code <= ip6val_pkg::CHAR_UF) ||
                 (char_code >= ip6val_pkg::CHAR_LA && char_code <= ip6val_pkg::CHAR_LF))
        begin
            item.cls = ip6val_pkg::CLS_HEX;
        end
        else if (char_code == ip6val_pkg::CHAR_COLON)
        begin
            item.cls = ip6val_pkg::CLS_COLON;
        end
        else if (char_code == ip6val_pkg::CHAR_DOT)
        begin
            item.cls = ip6val_pkg::CLS_DOT;
        end
        else
        begin
            item.cls = ip6val_pkg::CLS_BAD;
        end
    end

endmodule

// ----- design/ip6val_queue.sv -----
module ip6val_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ip6val_pkg::item_t  wr_item,
    output logic               full,
    input  logic               pop,
    output logic               rd_valid,
    output ip6val_pkg::item_t  rd_item
);

    ip6val_pkg::item_t                 mem_reg [ip6val_pkg::QUEUE_DEPTH];
    logic [ip6val_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ip6val_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [ip6val_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ip6val_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [ip6val_pkg::QCNT_W-1:0]     count_reg;
    logic [ip6val_pkg::QCNT_W-1:0]     count_next;

    assign full     = (count_reg == ip6val_pkg::QCNT_W'(ip6val_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == ip6val_pkg::QPTR_W'(ip6val_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ip6val_pkg::QPTR_W'(ip6val_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ----- design/ip6val_back.sv -----
module ip6val_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ip6val_pkg::item_t  in_item,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               valid_res,
    output logic [3:0]         reason
);

    logic [ip6val_pkg::SEG_W-1:0]      seg_reg;
    logic [ip6val_pkg::SEG_W-1:0]      seg_next;
    logic [1:0]                        colon_run_reg;
    logic [1:0]                        colon_run_next;
    logic                              dcolon_reg;
    logic                              dcolon_next;
    logic [ip6val_pkg::DOT_W-1:0]      dot_reg;
    logic [ip6val_pkg::DOT_W-1:0]      dot_next;
    logic [ip6val_pkg::HEX_W-1:0]      hex_run_reg;
    logic [ip6val_pkg::HEX_W-1:0]      hex_run_next;
    logic [ip6val_pkg::DEC_W-1:0]      dec_reg;
    logic [ip6val_pkg::DEC_W-1:0]      dec_next;
    logic                              dotted_reg;
    logic                              dotted_next;
    ip6val_pkg::colon_err_t            cerr_reg;
    ip6val_pkg::colon_err_t            cerr_next;
    ip6val_pkg::char_err_t             xerr_reg;
    ip6val_pkg::char_err_t             xerr_next;
    ip6val_pkg::char_err_t             xerr_item;
    logic [ip6val_pkg::DEC_PROD_W-1:0] dec_ext;
    logic [ip6val_pkg::DEC_PROD_W-1:0] dec_prod;
    ip6val_pkg::reason_t               verdict;
    logic                              produces;
    logic                              out_valid_reg;
    logic                              out_valid_next;
    logic                              res_reg;
    ip6val_pkg::reason_t               reason_reg;

    assign produces  = in_item.last || in_item.empty;
    assign pop       = in_valid && (!produces || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign valid_res = res_reg;
    assign reason    = reason_reg;

    assign dec_ext  = ip6val_pkg::DEC_PROD_W'(dec_reg);
    assign dec_prod = (dec_ext << 3) + (dec_ext << 1) +
                      ip6val_pkg::DEC_PROD_W'(in_item.digit);

    always_comb
    begin
        seg_next       = seg_reg;
        colon_run_next = colon_run_reg;
        dcolon_next    = dcolon_reg;
        dot_next       = dot_reg;
        cerr_next      = cerr_reg;
        if (cerr_reg == ip6val_pkg::CERR_NONE)
        begin
            case (in_item.cls)
                ip6val_pkg::CLS_COLON:
                begin
                    if (colon_run_reg > 2'd1)
                    begin
                        cerr_next = ip6val_pkg::CERR_TRIPLE;
                    end
                    else if (colon_run_reg == 2'd1 && dcolon_reg)
                    begin
                        cerr_next = ip6val_pkg::CERR_DOUBLE;
                    end
                    else
                    begin
                        if (colon_run_reg == 2'd1)
                        begin
                            dcolon_next = 1'b1;
                        end
                        colon_run_next = colon_run_reg + 2'd1;
                    end
                end
                ip6val_pkg::CLS_DOT:
                begin
                    if (dot_reg < ip6val_pkg::DOT_W'(ip6val_pkg::DOT_LIMIT))
                    begin
                        dot_next = dot_reg + 1'b1;
                    end
                end
                default:
                begin
                    if (colon_run_reg != 2'd0 &&
                        seg_reg < ip6val_pkg::SEG_W'(ip6val_pkg::MAX_GROUPS + 1))
                    begin
                        seg_next = seg_reg + 1'b1;
                    end
                    colon_run_next = 2'd0;
                end
            endcase
        end
    end

    always_comb
    begin
        hex_run_next = hex_run_reg;
        dotted_next  = dotted_reg;
        xerr_item    = ip6val_pkg::XERR_NONE;
        case (in_item.cls) inside
            ip6val_pkg::CLS_DEC, ip6val_pkg::CLS_HEX:
            begin
                if (hex_run_reg < ip6val_pkg::HEX_W'(ip6val_pkg::MAX_HEX_DIGITS + 1))
                begin
                    hex_run_next = hex_run_reg + 1'b1;
                end
                if (hex_run_next > ip6val_pkg::HEX_W'(ip6val_pkg::MAX_HEX_DIGITS))
                begin
                    xerr_item = ip6val_pkg::XERR_HEXLONG;
                end
            end
            ip6val_pkg::CLS_DOT:
            begin
                hex_run_next = '0;
                dotted_next  = 1'b1;
                if (dec_reg > ip6val_pkg::DEC_W'(ip6val_pkg::DEC_MAX))
                begin
                    xerr_item = ip6val_pkg::XERR_DECIMAL;
                end
            end
            ip6val_pkg::CLS_COLON:
            begin
                hex_run_next = '0;
            end
            default:
            begin
                xerr_item = ip6val_pkg::XERR_BAD;
            end
        endcase
        if (in_item.cls == ip6val_pkg::CLS_DEC)
        begin
            dec_next = (dec_prod > ip6val_pkg::DEC_PROD_W'(ip6val_pkg::DEC_SAT)) ?
                       ip6val_pkg::DEC_W'(ip6val_pkg::DEC_SAT) :
                       dec_prod[ip6val_pkg::DEC_W-1:0];
        end
        else
        begin
            dec_next = '0;
        end
        xerr_next = (xerr_reg == ip6val_pkg::XERR_NONE) ? xerr_item : xerr_reg;
    end

    always_comb
    begin
        if (in_item.empty)
        begin
            verdict = ip6val_pkg::R_EMPTY;
        end
        else if (cerr_next == ip6val_pkg::CERR_TRIPLE)
        begin
            verdict = ip6val_pkg::R_TRIPLE;
        end
        else if (cerr_next == ip6val_pkg::CERR_DOUBLE)
        begin
            verdict = ip6val_pkg::R_DOUBLE2;
        end
        else if (dot_next != ip6val_pkg::DOT_W'(0) && dot_next != ip6val_pkg::DOT_W'(3))
        begin
            verdict = ip6val_pkg::R_DOTS;
        end
        else if (seg_next > ip6val_pkg::SEG_W'(ip6val_pkg::MAX_GROUPS))
        begin
            verdict = ip6val_pkg::R_SEGS;
        end
        else if (xerr_next == ip6val_pkg::XERR_BAD)
        begin
            verdict = ip6val_pkg::R_BADCHAR;
        end
        else if (xerr_next == ip6val_pkg::XERR_HEXLONG)
        begin
            verdict = ip6val_pkg::R_HEXLONG;
        end
        else if (xerr_next == ip6val_pkg::XERR_DECIMAL)
        begin
            verdict = ip6val_pkg::R_DECIMAL;
        end
        else if (dotted_next && dec_next > ip6val_pkg::DEC_W'(ip6val_pkg::DEC_MAX))
        begin
            verdict = ip6val_pkg::R_DECIMAL;
        end
        else
        begin
            verdict = ip6val_pkg::R_OK;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (pop && produces)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= ip6val_pkg::SEG_W'(1);
            colon_run_reg <= 2'd0;
            dcolon_reg    <= 1'b0;
            dot_reg       <= '0;
            hex_run_reg   <= '0;
            dec_reg       <= '0;
            dotted_reg    <= 1'b0;
            cerr_reg      <= ip6val_pkg::CERR_NONE;
            xerr_reg      <= ip6val_pkg::XERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                if (produces)
                begin
                    seg_reg       <= ip6val_pkg::SEG_W'(1);
                    colon_run_reg <= 2'd0;
                    dcolon_reg    <= 1'b0;
                    dot_reg       <= '0;
                    hex_run_reg   <= '0;
                    dec_reg       <= '0;
                    dotted_reg    <= 1'b0;
                    cerr_reg      <= ip6val_pkg::CERR_NONE;
                    xerr_reg      <= ip6val_pkg::XERR_NONE;
                end
                else
                begin
                    seg_reg       <= seg_next;
                    colon_run_reg <= colon_run_next;
                    dcolon_reg    <= dcolon_next;
                    dot_reg       <= dot_next;
                    hex_run_reg   <= hex_run_next;
                    dec_reg       <= dec_next;
                    dotted_reg    <= dotted_next;
                    cerr_reg      <= cerr_next;
                    xerr_reg      <= xerr_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && produces)
        begin
            res_reg    <= (verdict == ip6val_pkg::R_OK);
            reason_reg <= verdict;
        end
    end

    a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        pop && produces |=> seg_reg == ip6val_pkg::SEG_W'(1) && colon_run_reg == 2'd0 &&
                            cerr_reg == ip6val_pkg::CERR_NONE)
        else $error("scan state not cleared after verdict");

    a_counter_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        colon_run_reg <= 2'd2 && dot_reg <= ip6val_pkg::DOT_W'(ip6val_pkg::DOT_LIMIT) &&
        hex_run_reg <= ip6val_pkg::HEX_W'(ip6val_pkg::MAX_HEX_DIGITS + 1) &&
        dec_reg <= ip6val_pkg::DEC_W'(ip6val_pkg::DEC_SAT))
        else $error("scan counter out of range");

    a_verdict_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg == (reason_reg == ip6val_pkg::R_OK))
        else $error("valid flag disagrees with reason");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(reason_reg))
        else $error("pending verdict overwritten");

endmodule

// ----- design/ipv6_literal_validator_top.sv -----
// Path: an item accepted on the slave side is decoded and written into the queue; the
// back end scans it from the queue head and registers its verdict onto the master side.
// Throughput: one item per cycle while no verdict waits on the master side, set by the
// scan update in the back end; the two-entry queue holds items while a verdict waits on
// a stalled master side, and the input stalls once it is full.
// Reset (rst_n low, asynchronous): empties the queue, drops any pending verdict and
// returns the scan state to its start; each verdict, empty items included, resets the scan state.
module ipv6_literal_validator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,
    input  logic       s_axis_tuser,   // [0] empty_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] valid_res, [4:1] reason, [7:5] zero
);

    ip6val_pkg::item_t front_item;
    ip6val_pkg::item_t queue_item;
    logic              queue_full;
    logic              queue_valid;
    logic              queue_pop;
    logic              res_bit;
    logic [3:0]        res_reason;

    assign s_axis_tready = !queue_full;
    assign m_axis_tdata  = {3'b000, res_reason, res_bit};

    ip6val_front u_front (
        .char_code  (s_axis_tdata),
        .last_char  (s_axis_tlast),
        .empty_text (s_axis_tuser),
        .item       (front_item)
    );

    ip6val_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_axis_tvalid && !queue_full),
        .wr_item  (front_item),
        .full     (queue_full),
        .pop      (queue_pop),
        .rd_valid (queue_valid),
        .rd_item  (queue_item)
    );

    ip6val_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_item   (queue_item),
        .pop       (queue_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .valid_res (res_bit),
        .reason    (res_reason)
    );

endmodule
